### design/iale_pkg.sv
// shared types and codes for the indexed array list engine
package iale_pkg;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		MODE_INSERT_AT  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_PUSH_BACK  = 3'd2,
		MODE_DELETE_AT  = 3'd3,
		MODE_GET        = 3'd4,
		MODE_LOCATE     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_BAD_POS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_FIN  = 2'd2,
		ST_RESP = 2'd3
	} state_t;

	typedef struct packed {
		mode_t                   mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] read_value;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        count;
	} rsp_t;

endpackage

### design/iale_list_mem.sv
// list word storage: one write port, one registered read port
module iale_list_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/indexed_array_list_engine_unit.sv
// indexed array list engine: packed 1-based list with shift, read and search
// a result strobes done after start once the n words are moved, scanned or read
// (up to CAPACITY for locate); full list, bad position or unused mode skip straight to the response
// throughput: one request at a time, bounded by the single memory read port, one word per cycle
// busy stays high from the accepting edge through the done cycle; done is a one-cycle strobe
// reset empties the list (count zero); stored words are not cleared
module indexed_array_list_engine_unit import iale_pkg::*; #(
	parameter int CAPACITY   = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t                  state_q, state_d;
	mode_t                   mode_q;
	status_t                 status_q, acc_status;
	logic [DATA_WIDTH-1:0]   word_q;
	logic [CW-1:0]           cnt_q, left_q, acc_moves;
	logic [IW-1:0]           addr_q, ins_idx_q, acc_addr, addr_s1;
	logic signed [VAL_W-1:0] rd_q;
	logic [POS_W-1:0]        found_q;
	logic                    hit_q, rdv_s1;
	logic [DATA_WIDTH-1:0]   rdata_s1;

	logic [PW-1:0] pos_ext, cnt_ext, p0;
	logic          pos_ok, full, accept, go_run, acc_ins, ins_q;
	logic          issue, fin;
	logic                  mem_we;
	logic [IW-1:0]         mem_wa;
	logic [DATA_WIDTH-1:0] mem_wd;

	assign accept  = start && !busy;
	assign pos_ext = PW'(req.position);
	assign cnt_ext = PW'(cnt_q);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign acc_ins = (req.mode == MODE_INSERT_AT) || (req.mode == MODE_PUSH_FRONT) ||
	                 (req.mode == MODE_PUSH_BACK);
	assign ins_q   = (mode_q == MODE_INSERT_AT) || (mode_q == MODE_PUSH_FRONT) ||
	                 (mode_q == MODE_PUSH_BACK);

	// request decode: zero-based target index, range check, move count and first address
	always_comb begin
		p0        = '0;
		pos_ok    = 1'b1;
		acc_moves = '0;
		acc_addr  = '0;
		case (req.mode)
			MODE_INSERT_AT: begin
				p0        = pos_ext - PW'(1);
				pos_ok    = (req.position != '0) && (p0 <= cnt_ext);
				acc_moves = CW'(cnt_ext - p0);
				acc_addr  = IW'(cnt_ext - PW'(1));
			end
			MODE_PUSH_FRONT: begin
				p0        = '0;
				acc_moves = cnt_q;
				acc_addr  = IW'(cnt_ext - PW'(1));
			end
			MODE_PUSH_BACK: begin
				p0        = cnt_ext;
				acc_addr  = IW'(cnt_ext - PW'(1));
			end
			MODE_DELETE_AT: begin
				p0        = pos_ext - PW'(1);
				pos_ok    = (req.position != '0) && (p0 < cnt_ext);
				acc_moves = CW'(cnt_ext - p0 - PW'(1));
				acc_addr  = IW'(p0 + PW'(1));
			end
			MODE_GET: begin
				p0        = pos_ext - PW'(1);
				pos_ok    = (req.position != '0) && (p0 < cnt_ext);
				acc_moves = CW'(1);
				acc_addr  = IW'(p0);
			end
			MODE_LOCATE: begin
				acc_moves = cnt_q;
				acc_addr  = '0;
			end
			default: begin
				pos_ok = 1'b1;
			end
		endcase
	end

	always_comb begin
		if (acc_ins && full) begin
			acc_status = STATUS_FULL;
		end else if (!pos_ok) begin
			acc_status = STATUS_BAD_POS;
		end else begin
			acc_status = STATUS_OK;
		end
	end

	assign go_run = (acc_status == STATUS_OK) && (req.mode <= MODE_LOCATE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = go_run ? ST_SCAN : ST_RESP;
				end
			end
			ST_SCAN: begin
				if ((left_q == '0) && !rdv_s1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = 1'b1;
		done  = 1'b0;
		issue = 1'b0;
		fin   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				issue = (left_q != '0);
			end
			ST_FIN: begin
				fin = 1'b1;
			end
			ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// write port: shifted word one slot over, then the new word on insert
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = rdata_s1;
		if (rdv_s1 && ins_q) begin
			mem_we = 1'b1;
			mem_wa = addr_s1 + IW'(1);
		end else if (rdv_s1 && (mode_q == MODE_DELETE_AT)) begin
			mem_we = 1'b1;
			mem_wa = addr_s1 - IW'(1);
		end else if (fin && ins_q) begin
			mem_we = 1'b1;
			mem_wa = ins_idx_q;
			mem_wd = word_q;
		end
	end

	iale_list_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (addr_q),
		.rdata (rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= issue;
			if (accept) begin
				left_q <= go_run ? acc_moves : '0;
			end else if (issue) begin
				left_q <= left_q - CW'(1);
			end
			if (fin && ins_q) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (fin && (mode_q == MODE_DELETE_AT)) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept) begin
			mode_q    <= req.mode;
			word_q    <= DATA_WIDTH'($unsigned(req.value));
			status_q  <= acc_status;
			addr_q    <= acc_addr;
			ins_idx_q <= IW'(p0);
			rd_q      <= '0;
			found_q   <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (issue) begin
				addr_q <= ins_q ? (addr_q - IW'(1)) : (addr_q + IW'(1));
			end
			if (rdv_s1 && (mode_q == MODE_GET)) begin
				rd_q <= VAL_W'($signed(rdata_s1));
			end
			// first match wins
			if (rdv_s1 && (mode_q == MODE_LOCATE) && !hit_q && (rdata_s1 == word_q)) begin
				hit_q   <= 1'b1;
				found_q <= POS_W'(CW'(addr_s1) + CW'(1));
			end
		end
	end

	assign rsp.status         = status_q;
	assign rsp.read_value     = rd_q;
	assign rsp.found_position = found_q;
	assign rsp.count          = POS_W'(cnt_q);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("list store written while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

endmodule
